>>> sv/rbsi_pkg.sv
package rbsi_pkg;

    // Quotient magnitude bits kept by the divider (enough to see saturation).
    localparam int QB      = 33;
    // Divider depth: one input stage, one stage per quotient bit, one output stage.
    localparam int DIV_LAT = QB + 2;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_X = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Y = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;
    localparam logic [2:0] FACE_POS_Z = 3'd6;

    typedef struct packed {
        logic signed [31:0] box_center_x;
        logic signed [31:0] box_center_y;
        logic signed [31:0] box_center_z;
        logic [30:0]        box_half_x;
        logic [30:0]        box_half_y;
        logic [30:0]        box_half_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_in_word;

    typedef struct packed {
        logic               is_hit;
        logic signed [31:0] near_param;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [2:0]         face_code;
    } t_out_word;

    // One magnitude division request: remainder seed, low numerator bits, divisor, sign and overflow flags.
    typedef struct packed {
        logic [QB-1:0] num_low;
        logic [QB-1:0] rem0;
        logic [31:0]   den;
        logic          neg;
        logic          ovf;
    } t_div_req;

    // Per-item data that rides beside the dividers.
    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
        logic             slab_miss;
    } t_side;

    typedef struct packed {
        logic             miss;
        logic [31:0]      near;
        logic [2:0]       face;
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } t_res;

endpackage

>>> sv/ray_box_slab_intersection.sv
// Ray versus axis-aligned box test by the slab method, signed fixed point.
// Input channel (i_in_valid / i_in_data / o_in_stall): one word carries one
// box (center, half extents) and one ray (origin, direction). A word is taken
// at a rising edge with i_in_valid high and o_in_stall low.
// Output channel (o_out_valid / o_out_data / i_out_stall): one result word per
// input word, in order: hit flag, entry parameter, hit point and face code.
// Path: prep, six bit-per-cycle dividers (one per slab plane, stepping while
// the pipe is not held), resolve, hit point and the output register.
// Throughput: one word per cycle, sustained, as long as the output drains.
// Reset (i_rst_n low at a rising edge) clears every valid bit; in-flight
// words are dropped and payload registers keep whatever they held.
// Stall: the output register holds its word while i_out_stall is high. One
// more word lands in the skid register; then o_in_stall rises and the whole
// pipe holds until the output drains. Nothing is lost or repeated.
module ray_box_slab_intersection
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_data,
    input  logic      i_out_stall
);

    // Global advance: the pipe moves whenever the skid slot is free.
    logic             en;
    logic             pop;

    logic             prep_valid;
    t_div_req [2:0]   req_lo, req_hi;
    t_side            prep_side;

    logic [2:0][31:0] t_lo, t_hi;

    // Side data delay line, matched to the divider latency.
    logic             r_sd_valid [0:DIV_LAT-1];
    t_side            r_sd       [0:DIV_LAT-1];

    logic             res_valid;
    t_res             res;
    logic             tail_valid;
    t_out_word        tail_word;

    logic             r_out_valid, r_skid_valid;
    t_out_word        r_out, r_skid;

    assign en  = !r_skid_valid;
    assign pop = r_out_valid && !i_out_stall;

    rbsi_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_word   (i_in_data),
        .o_valid  (prep_valid),
        .o_req_lo (req_lo),
        .o_req_hi (req_hi),
        .o_side   (prep_side)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_divider u_div_lo (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_req  (req_lo[a]),
            .o_quot (t_lo[a])
        );
        rbsi_divider u_div_hi (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_req  (req_hi[a]),
            .o_quot (t_hi[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_sd_valid[k] <= 1'b0;
        end else if (en) begin
            r_sd_valid[0] <= prep_valid;
            for (int k = 1; k < DIV_LAT; k++) r_sd_valid[k] <= r_sd_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= prep_side;
            for (int k = 1; k < DIV_LAT; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    rbsi_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sd_valid[DIV_LAT-1]),
        .i_side  (r_sd[DIV_LAT-1]),
        .i_t_lo  (t_lo),
        .i_t_hi  (t_hi),
        .o_valid (res_valid),
        .o_res   (res)
    );

    rbsi_hitpoint #(.FRAC_BITS(FRAC_BITS)) u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (res_valid),
        .i_res   (res),
        .o_valid (tail_valid),
        .o_word  (tail_word)
    );

    // Output register plus skid slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // pipe is held; once the output is taken, refill it from the skid slot
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (tail_valid) begin
            if (!r_out_valid || pop) begin
                r_out       <= tail_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= tail_word;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/rbsi_prep.sv
module rbsi_prep
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_in_word            i_word,
    output logic                o_valid,
    output t_div_req [2:0]      o_req_lo,
    output t_div_req [2:0]      o_req_hi,
    output t_side               o_side
);

    localparam int NW = 35 + FRAC_BITS;
    localparam int RW = NW - QB;

    logic [2:0][31:0] c_v, o_v, d_v;
    logic [2:0][30:0] h_v;
    logic [2:0][34:0] n1_dlo, n1_dhi;

    logic             r1_valid;
    logic [2:0][34:0] r1_dlo, r1_dhi;
    logic [2:0][31:0] r1_o, r1_d;

    logic             r2_valid;
    t_div_req [2:0]   r2_req_lo, r2_req_hi;
    t_side            r2_side;
    t_div_req [2:0]   n2_req_lo, n2_req_hi;
    logic             n2_miss;

    function automatic t_div_req mk_req(input logic [34:0] diff, input logic [31:0] d);
        logic [34:0]   mag;
        logic [31:0]   dmag;
        logic [NW-1:0] num;
        logic [RW-1:0] r0;
        t_div_req      q;
        mag       = diff[34] ? (~diff + 35'd1) : diff;
        dmag      = d[31] ? (~d + 32'd1) : d;
        num       = {mag, {FRAC_BITS{1'b0}}};
        r0        = num[NW-1:QB];
        q.num_low = num[QB-1:0];
        q.rem0    = QB'(r0);
        q.den     = dmag;
        q.neg     = diff[34] ^ d[31];
        q.ovf     = QB'(r0) >= {1'b0, dmag};
        return q;
    endfunction

    assign c_v = {i_word.box_center_z, i_word.box_center_y, i_word.box_center_x};
    assign h_v = {i_word.box_half_z, i_word.box_half_y, i_word.box_half_x};
    assign o_v = {i_word.origin_z, i_word.origin_y, i_word.origin_x};
    assign d_v = {i_word.dir_z, i_word.dir_y, i_word.dir_x};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n1_dlo[a] = {{3{c_v[a][31]}}, c_v[a]} - {4'b0, h_v[a]} - {{3{o_v[a][31]}}, o_v[a]};
            n1_dhi[a] = {{3{c_v[a][31]}}, c_v[a]} + {4'b0, h_v[a]} - {{3{o_v[a][31]}}, o_v[a]};
        end
    end

    always_comb begin
        n2_miss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            n2_req_lo[a] = mk_req(r1_dlo[a], r1_d[a]);
            n2_req_hi[a] = mk_req(r1_dhi[a], r1_d[a]);
            // zero direction: origin must lie inside the slab
            if (r1_d[a] == 32'd0 &&
                !((r1_dlo[a][34] || r1_dlo[a] == 35'd0) && !r1_dhi[a][34])) begin
                n2_miss = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dlo            <= n1_dlo;
            r1_dhi            <= n1_dhi;
            r1_o              <= o_v;
            r1_d              <= d_v;
            r2_req_lo         <= n2_req_lo;
            r2_req_hi         <= n2_req_hi;
            r2_side.o         <= r1_o;
            r2_side.d         <= r1_d;
            r2_side.slab_miss <= n2_miss;
        end
    end

    assign o_valid  = r2_valid;
    assign o_req_lo = r2_req_lo;
    assign o_req_hi = r2_req_hi;
    assign o_side   = r2_side;

endmodule

>>> sv/rbsi_divider.sv
module rbsi_divider
    import rbsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_div_req    i_req,
    output logic [31:0] o_quot
);

    logic [QB-1:0] r_rem [0:QB];
    logic [QB-1:0] r_num [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [31:0]   r_den [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];

    logic [QB-1:0] n_rem [0:QB-1];
    logic [QB-1:0] n_q   [0:QB-1];

    logic [QB-1:0] mag;
    logic [31:0]   n_quot, r_quot;

    // One restoring step per stage, most significant quotient bit first.
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            logic [QB-1:0] trial;
            logic          take;
            trial    = {r_rem[k][QB-2:0], r_num[k][QB-1]};
            take     = trial >= {1'b0, r_den[k]};
            n_rem[k] = take ? (trial - {1'b0, r_den[k]}) : trial;
            n_q[k]   = {r_q[k][QB-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_req.rem0;
            r_num[0] <= i_req.num_low;
            r_q[0]   <= '0;
            r_den[0] <= i_req.den;
            r_neg[0] <= i_req.neg;
            r_ovf[0] <= i_req.ovf;
            for (int k = 0; k < QB; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_num[k+1] <= {r_num[k][QB-2:0], 1'b0};
                r_q[k+1]   <= n_q[k];
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
            r_quot <= n_quot;
        end
    end

    // Apply sign (truncation toward zero) and saturate.
    assign mag = r_q[QB];
    always_comb begin
        if (r_ovf[QB]) begin
            n_quot = r_neg[QB] ? S32_MIN : S32_MAX;
        end else if (!r_neg[QB]) begin
            n_quot = (mag > {1'b0, S32_MAX}) ? S32_MAX : mag[31:0];
        end else begin
            n_quot = (mag > {1'b0, S32_MIN}) ? S32_MIN : (~mag[31:0] + 32'd1);
        end
    end

    assign o_quot = r_quot;

endmodule

>>> sv/rbsi_resolve.sv
module rbsi_resolve
    import rbsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [2:0][31:0] i_t_lo,
    input  logic [2:0][31:0] i_t_hi,
    output logic             o_valid,
    output t_res             o_res
);

    logic             r1_valid, r2_valid, r3_valid;
    logic [2:0][31:0] r1_entry, r1_exit, r2_entry;
    logic [2:0]       r1_lim, r2_lim;
    t_side            r1_side, r2_side;
    logic [31:0]      r2_near, r2_far;
    t_res             r3_res;

    logic [2:0][31:0] n1_entry, n1_exit;
    logic [2:0]       n1_lim;
    logic [31:0]      n2_near, n2_far;
    logic [2:0]       n3_face;
    logic             n3_miss;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n1_lim[a] = i_side.d[a] != 32'd0;
            if ($signed(i_t_lo[a]) < $signed(i_t_hi[a])) begin
                n1_entry[a] = i_t_lo[a];
                n1_exit[a]  = i_t_hi[a];
            end else begin
                n1_entry[a] = i_t_hi[a];
                n1_exit[a]  = i_t_lo[a];
            end
        end
    end

    always_comb begin
        n2_near = S32_MIN;
        n2_far  = S32_MAX;
        for (int a = 0; a < 3; a++) begin
            if (r1_lim[a] && $signed(r1_entry[a]) > $signed(n2_near)) n2_near = r1_entry[a];
            if (r1_lim[a] && $signed(r1_exit[a]) < $signed(n2_far)) n2_far = r1_exit[a];
        end
    end

    always_comb begin
        n3_miss = r2_side.slab_miss || ($signed(r2_near) > $signed(r2_far)) || r2_far[31];
        priority if (r2_lim[0] && r2_entry[0] == r2_near) begin
            n3_face = r2_side.d[0][31] ? FACE_POS_X : FACE_NEG_X;
        end else if (r2_lim[1] && r2_entry[1] == r2_near) begin
            n3_face = r2_side.d[1][31] ? FACE_POS_Y : FACE_NEG_Y;
        end else if (r2_lim[2] && r2_entry[2] == r2_near) begin
            n3_face = r2_side.d[2][31] ? FACE_POS_Z : FACE_NEG_Z;
        end else begin
            n3_face = FACE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_entry    <= n1_entry;
            r1_exit     <= n1_exit;
            r1_lim      <= n1_lim;
            r1_side     <= i_side;
            r2_entry    <= r1_entry;
            r2_lim      <= r1_lim;
            r2_side     <= r1_side;
            r2_near     <= n2_near;
            r2_far      <= n2_far;
            r3_res.miss <= n3_miss;
            r3_res.near <= r2_near;
            r3_res.face <= n3_face;
            r3_res.o    <= r2_side.o;
            r3_res.d    <= r2_side.d;
        end
    end

    assign o_valid = r3_valid;
    assign o_res   = r3_res;

endmodule

>>> sv/rbsi_hitpoint.sv
module rbsi_hitpoint
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_res      i_res,
    output logic      o_valid,
    output t_out_word o_word
);

    logic             r1_valid, r2_valid;
    logic [2:0][63:0] r1_prod;
    logic             r1_miss;
    logic [31:0]      r1_near;
    logic [2:0]       r1_face;
    logic [2:0][31:0] r1_o;
    t_out_word        r2_word, n2_word;
    logic [2:0][31:0] n2_hit;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [63:0] sh;
            logic signed [64:0] sum;
            sh  = $signed(r1_prod[a]) >>> FRAC_BITS;
            sum = {sh[63], sh} + {{33{r1_o[a][31]}}, r1_o[a]};
            if (sum > 65'(S32_MAX)) begin
                n2_hit[a] = S32_MAX;
            end else if (sum < 65'(S32_MIN)) begin
                n2_hit[a] = S32_MIN;
            end else begin
                n2_hit[a] = sum[31:0];
            end
        end
        if (r1_miss) begin
            n2_word = '0;
        end else begin
            n2_word.is_hit     = 1'b1;
            n2_word.near_param = r1_near;
            n2_word.hit_x      = n2_hit[0];
            n2_word.hit_y      = n2_hit[1];
            n2_word.hit_z      = n2_hit[2];
            n2_word.face_code  = r1_face;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_prod[a] <= 64'($signed(i_res.d[a]) * $signed(i_res.near));
            end
            r1_miss <= i_res.miss;
            r1_near <= i_res.near;
            r1_face <= i_res.face;
            r1_o    <= i_res.o;
            r2_word <= n2_word;
        end
    end

    assign o_valid = r2_valid;
    assign o_word  = r2_word;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

// Testbench for ray_box_slab_intersection.
// A directed table covers the extremes first; random words come after it.
// Every word the block takes is run through a behavioral slab-test predictor,
// and the expected word is queued. Each result the block hands over is checked
// field by field against the oldest queued word.
module tb;
    import rbsi_pkg::*;

    localparam int FRAC   = 16;
    localparam int LAT    = 42;
    localparam int N_RAND = 500;
    localparam int WDOG   = 4000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_word  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_data;
    logic      i_out_stall;

    ray_box_slab_intersection #(.FRAC_BITS(FRAC)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    // One directed row. has_exp marks rows whose answer is typed in by hand.
    typedef struct {
        t_in_word  w;
        bit        has_exp;
        t_out_word exp_w;
    } t_row;

    t_out_word hit_queue[$];
    int        n_fail      = 0;
    int        n_row_fail  = 0;
    int        idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Saturate a wide value into the signed 32-bit range.
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647) return S32_MAX;
        if (x < -128'sd2147483648) return S32_MIN;
        return x[31:0];
    endfunction

    // Slab parameter: (bound - o) * 2^FRAC / d, truncated toward zero.
    function automatic logic signed [31:0] slab_param(input logic signed [127:0] bound,
                                                      input logic signed [127:0] o,
                                                      input logic signed [127:0] d);
        logic signed [127:0] num;
        num = (bound - o) <<< FRAC;
        return clamp32(num / d);
    endfunction

    // Floor division of a signed product by 2^FRAC.
    function automatic logic signed [127:0] floor_frac(input logic signed [127:0] p);
        return p >>> FRAC;
    endfunction

    function automatic t_out_word predict_slab_hit(input t_in_word w);
        logic signed [127:0] c[3], h[3], o[3], d[3];
        logic signed [127:0] lo, hi, t0, t1, near_t, far_t;
        logic signed [127:0] entry[3];
        bit                  lim[3];
        bit                  miss;
        t_out_word           r;
        c[0] = w.box_center_x; c[1] = w.box_center_y; c[2] = w.box_center_z;
        h[0] = {97'd0, w.box_half_x}; h[1] = {97'd0, w.box_half_y};
        h[2] = {97'd0, w.box_half_z};
        o[0] = w.origin_x; o[1] = w.origin_y; o[2] = w.origin_z;
        d[0] = w.dir_x; d[1] = w.dir_y; d[2] = w.dir_z;
        near_t = -128'sd2147483648;
        far_t  = 128'sd2147483647;
        miss   = 1'b0;
        r      = '0;
        for (int a = 0; a < 3; a++) begin
            lo = c[a] - h[a];
            hi = c[a] + h[a];
            lim[a] = 1'b0;
            entry[a] = near_t;
            if (d[a] == 0) begin
                if (o[a] < lo || o[a] > hi) miss = 1'b1;
            end else begin
                t0 = slab_param(lo, o[a], d[a]);
                t1 = slab_param(hi, o[a], d[a]);
                lim[a] = 1'b1;
                entry[a] = (t0 < t1) ? t0 : t1;
                if (entry[a] > near_t) near_t = entry[a];
                if (((t0 < t1) ? t1 : t0) < far_t) far_t = (t0 < t1) ? t1 : t0;
            end
        end
        if (near_t > far_t || far_t < 0) miss = 1'b1;
        if (miss) return r;
        r.is_hit     = 1'b1;
        r.near_param = near_t[31:0];
        r.face_code  = FACE_NONE;
        // First limiting axis whose entry equals near names the face entered.
        for (int a = 0; a < 3; a++) begin
            if (lim[a] && entry[a] == near_t) begin
                r.face_code = 3'(2 * a + ((d[a] > 0) ? 1 : 2));
                break;
            end
        end
        r.hit_x = clamp32(o[0] + floor_frac(d[0] * near_t));
        r.hit_y = clamp32(o[1] + floor_frac(d[1] * near_t));
        r.hit_z = clamp32(o[2] + floor_frac(d[2] * near_t));
        return r;
    endfunction

    function automatic t_in_word make_word(input int cx, cy, cz, hx, hy, hz,
                                           input int ox, oy, oz, dx, dy, dz);
        t_in_word w;
        w.box_center_x = cx; w.box_center_y = cy; w.box_center_z = cz;
        w.box_half_x = hx[30:0]; w.box_half_y = hy[30:0]; w.box_half_z = hz[30:0];
        w.origin_x = ox; w.origin_y = oy; w.origin_z = oz;
        w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
        return w;
    endfunction

    // Pick a field value: mostly small Q16.16, sometimes wide, extreme or zero.
    function automatic logic [31:0] pick_val(input bit near_box);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            2:       return 32'd0;
            default: return near_box ? 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16))
                                     : 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        logic [31:0] v;
        w.box_center_x = pick_val(1); w.box_center_y = pick_val(1);
        w.box_center_z = pick_val(1);
        v = pick_val(0); w.box_half_x = 31'((v[31] ? -v : v) >> ($urandom_range(0, 1)));
        v = pick_val(0); w.box_half_y = 31'((v[31] ? -v : v) >> ($urandom_range(0, 1)));
        v = pick_val(0); w.box_half_z = 31'((v[31] ? -v : v) >> ($urandom_range(0, 1)));
        w.origin_x = pick_val(1); w.origin_y = pick_val(1); w.origin_z = pick_val(1);
        // Aim most rays at the box so that hits are common.
        if ($urandom_range(0, 3) != 0) begin
            w.dir_x = w.box_center_x - w.origin_x + 32'($signed($urandom_range(0, 8192)) - 4096);
            w.dir_y = w.box_center_y - w.origin_y + 32'($signed($urandom_range(0, 8192)) - 4096);
            w.dir_z = w.box_center_z - w.origin_z + 32'($signed($urandom_range(0, 8192)) - 4096);
        end else begin
            w.dir_x = pick_val(0); w.dir_y = pick_val(0); w.dir_z = pick_val(0);
        end
        return w;
    endfunction

    // Append one expected word to the scoreboard.
    function automatic void queue_exp(input t_out_word e);
        hit_queue.insert(hit_queue.size(), e);
    endfunction

    // Hold the word until the block takes it; sender gaps come from the caller.
    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queue_exp(predict_slab_hit(w));
    endtask

    task automatic send_gap();
        i_in_valid <= 1'b0;
        i_in_data  <= random_word();
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    // Receiver stall pattern: quiet stretches alternate with choppy ones.
    initial begin
        int phase;
        i_out_stall = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase = (phase + 1) % 300;
            if (phase < 100) i_out_stall <= 1'b0;
            else if (phase < 200) i_out_stall <= ($urandom_range(0, 3) == 0);
            else i_out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // Check each taken result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_out_word e;
            if (hit_queue.size() == 0) begin
                $error("result word with no expectation pending");
                n_fail++;
            end else begin
                e = hit_queue.pop_front();
                if (o_out_data.is_hit !== e.is_hit) begin
                    $error("is_hit exp %0d got %0d", e.is_hit, o_out_data.is_hit);
                    n_fail++;
                end
                if (o_out_data.near_param !== e.near_param) begin
                    $error("near_param exp %0d got %0d", e.near_param, o_out_data.near_param);
                    n_fail++;
                end
                if (o_out_data.hit_x !== e.hit_x) begin
                    $error("hit_x exp %0d got %0d", e.hit_x, o_out_data.hit_x);
                    n_fail++;
                end
                if (o_out_data.hit_y !== e.hit_y) begin
                    $error("hit_y exp %0d got %0d", e.hit_y, o_out_data.hit_y);
                    n_fail++;
                end
                if (o_out_data.hit_z !== e.hit_z) begin
                    $error("hit_z exp %0d got %0d", e.hit_z, o_out_data.hit_z);
                    n_fail++;
                end
                if (o_out_data.face_code !== e.face_code) begin
                    $error("face_code exp %0d got %0d", e.face_code, o_out_data.face_code);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        int   one;
        one         = 1 << FRAC;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. Unit box at the origin unless noted.
        // Ray along +x from x=-4: enters the -x face at t=3.
        r.w = make_word(0, 0, 0, one, one, one, -4 * one, 0, 0, one, 0, 0);
        r.has_exp = 1; r.exp_w = '{1'b1, 3 * one, -one, 0, 0, FACE_NEG_X};
        rows.insert(rows.size(), r);
        // Ray along -y from y=+4: enters the +y face.
        r.w = make_word(0, 0, 0, one, one, one, 0, 4 * one, 0, 0, -one, 0);
        r.has_exp = 1; r.exp_w = '{1'b1, 3 * one, 0, one, 0, FACE_POS_Y};
        rows.insert(rows.size(), r);
        // Zero direction with the origin outside its slab: miss.
        r.w = make_word(0, 0, 0, one, one, one, -4 * one, 3 * one, 0, one, 0, 0);
        r.has_exp = 1; r.exp_w = '0;
        rows.insert(rows.size(), r);
        // All directions zero, origin inside: hit, no face, point is origin.
        r.w = make_word(0, 0, 0, one, one, one, 5, 6, 7, 0, 0, 0);
        r.has_exp = 1; r.exp_w = '{1'b1, S32_MIN, 5, 6, 7, FACE_NONE};
        rows.insert(rows.size(), r);
        // Box behind the ray: far negative, miss.
        r.w = make_word(0, 0, 0, one, one, one, 4 * one, 0, 0, one, 0, 0);
        r.has_exp = 1; r.exp_w = '0;
        rows.insert(rows.size(), r);
        r.has_exp = 0;
        // Origin inside the box, negative near; z axis entered through +z.
        r.w = make_word(0, 0, 0, one, one, one, 0, 0, 0, 0, 0, -one);
        rows.insert(rows.size(), r);
        r.w = make_word(0, 0, 0, one, one, one, 0, 0, -3 * one, 0, 0, one);
        rows.insert(rows.size(), r);
        // Corner hit: x and y tie, x wins the face.
        r.w = make_word(0, 0, 0, one, one, one, -3 * one, -3 * one, 0, one, one, 0);
        rows.insert(rows.size(), r);
        // Extremes of every field, in both signs.
        r.w = make_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, -1, 1);
        rows.insert(rows.size(), r);
        r.w = make_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        rows.insert(rows.size(), r);
        r.w = make_word(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        rows.insert(rows.size(), r);
        r.w = make_word(0, 0, 0, 0, 0, 0, -one, 0, 0, one, 0, 0);
        rows.insert(rows.size(), r);
        r.w = make_word(0, 0, 0, one, one, one, 32'h8000_0000, 0, 0, 1, 0, 0);
        rows.insert(rows.size(), r);
        r.w = make_word(-1, -1, -1, 32'h7fff_ffff, 1, 1, -1, -1, 32'h7fff_ffff,
                        -1, 1, -1);
        rows.insert(rows.size(), r);

        // Walk the table back to back, then at random pace.
        foreach (rows[k]) begin
            send_word(rows[k].w);
            if (rows[k].has_exp && predict_slab_hit(rows[k].w) !== rows[k].exp_w) begin
                $error("directed row %0d: hand answer disagrees with predictor", k);
                n_row_fail++;
            end
            // Check hand-typed rows against the typed answer.
            if (rows[k].has_exp) hit_queue[hit_queue.size() - 1] = rows[k].exp_w;
        end
        for (int n = 0; n < N_RAND; ) begin
            int burst;
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < N_RAND; b++, n++)
                send_word(random_word());
            if ($urandom_range(0, 2) != 0) send_gap();
        end
        i_in_valid <= 1'b0;

        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (2 * LAT) @(posedge i_clk);
        if (n_fail == 0 && n_row_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> ray_box_slab_intersection.f
sv/rbsi_pkg.sv
sv/rbsi_prep.sv
sv/rbsi_divider.sv
sv/rbsi_resolve.sv
sv/rbsi_hitpoint.sv
sv/ray_box_slab_intersection.sv
verif/tb.sv
